// ----- src/lpcrr_pkg.sv -----
// Shared widths, codes and helper functions for the linear-prediction residual engine.
package lpcrr_pkg;

  localparam int NUM_TAPS    = 32;
  localparam int SAMPLE_BITS = 32;

  localparam int DATA_W      = 32;
  localparam int COEF_W      = 16;
  localparam int MODE_W      = 2;
  localparam int COEF_IDX_W  = 5;
  localparam int ORDER_W     = 6;
  localparam int SHIFT_W     = 5;
  localparam int IDX_W       = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  localparam logic [MODE_W-1:0] MODE_LOAD_COEF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PREDICT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QSHIFT    = 2'd2;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

  // Incoming samples are taken as SAMPLE_BITS-bit two's complement values.
  function automatic logic signed [DATA_W-1:0] take_sample(input logic [DATA_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] t;
    t = v[SAMPLE_BITS-1:0];
    return DATA_W'(t);
  endfunction

endpackage

// ----- src/lpcrr_if.sv -----
// Request and result channel interfaces of the linear-prediction residual engine.
interface lpcrr_in_if;
  logic                                         valid;
  logic                                         ready;
  logic        [lpcrr_pkg::MODE_W-1:0]          mode;
  logic        [lpcrr_pkg::COEF_IDX_W-1:0]      coef_index;
  logic signed [lpcrr_pkg::COEF_W-1:0]          coef_value;
  logic signed [lpcrr_pkg::DATA_W-1:0]          in_value;
  logic                                         end_of_block;

  modport source (output valid, mode, coef_index, coef_value, in_value, end_of_block,
                  input ready);
  modport sink (input valid, mode, coef_index, coef_value, in_value, end_of_block,
                output ready);
endinterface

interface lpcrr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lpcrr_pkg::DATA_W-1:0] out_value;
  logic                                out_end_of_block;

  modport source (output valid, out_value, out_end_of_block, input ready);
  modport sink (input valid, out_value, out_end_of_block, output ready);
endinterface

// ----- src/lpcrr_mac.sv -----
// Shared multiply-accumulate unit with a registered product and a wrapping accumulator.
module lpcrr_mac (
  input  logic                                clk,
  input  lpcrr_pkg::mac_ctrl_t                ctrl,
  input  logic signed [lpcrr_pkg::COEF_W-1:0] coef,
  input  logic signed [lpcrr_pkg::DATA_W-1:0] sample,
  output logic        [lpcrr_pkg::DATA_W-1:0] acc
);

  localparam int PROD_W = lpcrr_pkg::COEF_W + lpcrr_pkg::DATA_W;

  logic signed [PROD_W-1:0]           product;
  logic        [lpcrr_pkg::DATA_W-1:0] prod_r;
  logic        [lpcrr_pkg::DATA_W-1:0] acc_r;

  assign product = coef * sample;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= product[lpcrr_pkg::DATA_W-1:0];
    end
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc = acc_r;

endmodule

// ----- src/lpc_residual_and_restore.sv -----
// Top level of the linear-prediction residual and restore engine.
// Coefficient loads (mode 0) and warm-up pushes (mode 1) take effect when accepted in idle,
// and mode 3 requests are ignored. A predict request (mode 2) steps through the taps: the one
// shared 16x32 multiplier feeds one tap per cycle into the accumulator, a drain state adds the
// last product, and a final state shifts the sum, forms the result and updates the history.
// The result waits in an output register, and the block takes new requests while it waits;
// a following predict holds in its final state until that register is free.
module lpc_residual_and_restore (
  input  logic                                    clk,
  input  logic                                    rst_n,
  lpcrr_in_if.sink                                in_ch,
  lpcrr_out_if.source                             out_ch,
  input  logic                                    cfg_we,
  input  logic [lpcrr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lpcrr_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic                                  direction_r;
  logic [lpcrr_pkg::ORDER_W-1:0]         order_r;
  logic [lpcrr_pkg::SHIFT_W-1:0]         qshift_r;

  logic signed [lpcrr_pkg::COEF_W-1:0]   coef_r [lpcrr_pkg::NUM_TAPS];
  logic signed [lpcrr_pkg::DATA_W-1:0]   hist_r [lpcrr_pkg::NUM_TAPS];

  logic [lpcrr_pkg::IDX_W-1:0]           cnt_r, cnt_nxt;
  logic [lpcrr_pkg::IDX_W-1:0]           order_last;
  logic [lpcrr_pkg::DATA_W-1:0]          value_r;
  logic                                  eob_r;

  logic                                  out_valid_r;
  logic signed [lpcrr_pkg::DATA_W-1:0]   out_value_r;
  logic                                  out_eob_r;

  logic                                  in_acc;
  logic                                  fin_go;
  logic                                  push_en;
  logic signed [lpcrr_pkg::DATA_W-1:0]   push_val;
  logic signed [lpcrr_pkg::DATA_W-1:0]   pred;
  logic signed [lpcrr_pkg::DATA_W-1:0]   sample;
  logic signed [lpcrr_pkg::DATA_W-1:0]   result;
  logic [lpcrr_pkg::DATA_W-1:0]          acc;
  lpcrr_pkg::mac_ctrl_t                  mac_ctrl;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign fin_go      = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (order_r == '0) begin
      order_last = '0;
    end else if (order_r > lpcrr_pkg::ORDER_W'(lpcrr_pkg::NUM_TAPS)) begin
      order_last = lpcrr_pkg::IDX_W'(lpcrr_pkg::NUM_TAPS - 1);
    end else begin
      order_last = lpcrr_pkg::IDX_W'(order_r - lpcrr_pkg::ORDER_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= lpcrr_pkg::DIR_ENCODE;
      order_r     <= lpcrr_pkg::ORDER_W'(1);
      qshift_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lpcrr_pkg::CFG_DIRECTION: direction_r <= cfg_wdata[0];
        lpcrr_pkg::CFG_ORDER:     order_r     <= cfg_wdata[lpcrr_pkg::ORDER_W-1:0];
        lpcrr_pkg::CFG_QSHIFT:    qshift_r    <= cfg_wdata[lpcrr_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mac_ctrl  = '0;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc && in_ch.mode == lpcrr_pkg::MODE_PREDICT) begin
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.clear  = (cnt_r == '0);
        mac_ctrl.acc_en = (cnt_r != '0);
        cnt_nxt         = cnt_r + lpcrr_pkg::IDX_W'(1);
        if (cnt_r == order_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        mac_ctrl.acc_en = 1'b1;
        state_nxt       = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r <= in_ch.in_value;
      eob_r   <= in_ch.end_of_block;
    end
  end

  lpcrr_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .coef   (coef_r[cnt_r]),
    .sample (hist_r[cnt_r]),
    .acc    (acc)
  );

  assign pred   = $signed(acc) >>> qshift_r;
  assign sample = (direction_r == lpcrr_pkg::DIR_DECODE) ? $signed(value_r)
                                                        : lpcrr_pkg::take_sample(value_r);
  assign result = (direction_r == lpcrr_pkg::DIR_DECODE) ? sample + pred : sample - pred;

  always_comb begin
    push_en  = 1'b0;
    push_val = lpcrr_pkg::take_sample(in_ch.in_value);
    if (fin_go) begin
      push_en  = 1'b1;
      push_val = (direction_r == lpcrr_pkg::DIR_DECODE) ? result : sample;
    end else if (in_acc && in_ch.mode == lpcrr_pkg::MODE_PUSH) begin
      push_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpcrr_pkg::NUM_TAPS; i++) begin
        coef_r[i] <= '0;
        hist_r[i] <= '0;
      end
    end else begin
      if (in_acc && in_ch.mode == lpcrr_pkg::MODE_LOAD_COEF &&
          32'(in_ch.coef_index) < 32'(lpcrr_pkg::NUM_TAPS)) begin
        coef_r[lpcrr_pkg::IDX_W'(in_ch.coef_index)] <= in_ch.coef_value;
      end
      if (push_en) begin
        for (int i = lpcrr_pkg::NUM_TAPS - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= push_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_value_r <= result;
      out_eob_r   <= eob_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.out_value        = out_value_r;
  assign out_ch.out_end_of_block = out_eob_r;

  a_predict_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.mode == lpcrr_pkg::MODE_PREDICT |=> state_r == S_MAC)
    else $error("predict request did not start the accumulation");

  a_drain_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |=> state_r == S_FIN)
    else $error("drain cycle not followed by the final cycle");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r && state_r == S_IDLE)
    else $error("final cycle did not load the output register");

  a_fin_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_valid_r && !out_ch.ready |=> state_r == S_FIN && out_valid_r)
    else $error("final cycle left while the output register was full");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result appeared without a finished prediction");

endmodule
